// ----- sv/osad_pkg.sv -----
package osad_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned IdW       = 64;
    localparam int unsigned FrameW    = 128;
    localparam int unsigned PosW      = 4;
    localparam int unsigned BitIdxW   = 6;
    localparam int unsigned PairsPerB = 4;
    localparam int unsigned FrameBytes = 16;
    localparam int unsigned OutDataW  = 200;

    // last search bit at which a discrepancy was taken toward 0
    typedef struct packed {
        logic               valid;
        logic [BitIdxW-1:0] bit_idx;
    } branch_t;

endpackage

// ----- sv/osad_byte_decode.sv -----
module osad_byte_decode (
    input  logic [osad_pkg::PosW-1:0]   pos,
    input  logic [osad_pkg::ByteW-1:0]  rbyte,
    input  logic [osad_pkg::IdW-1:0]    id_in,
    input  logic [osad_pkg::FrameW-1:0] frame_in,
    input  osad_pkg::branch_t           branch_in,
    output logic [osad_pkg::IdW-1:0]    id_out,
    output logic [osad_pkg::FrameW-1:0] frame_out,
    output osad_pkg::branch_t           branch_out
);

    // four (discrepancy, id) pairs per byte; byte at pos covers bits 4*pos..4*pos+3
    always_comb begin
        id_out     = id_in;
        frame_out  = frame_in;
        branch_out = branch_in;
        for (int k = 0; k < osad_pkg::PairsPerB; k++) begin
            // higher pairs override lower ones: keep the highest branch
            if (rbyte[2*k] && !rbyte[2*k+1]) begin
                branch_out.valid   = 1'b1;
                branch_out.bit_idx = {pos, 2'(k)};
            end
        end
        for (int i = 0; i < osad_pkg::FrameBytes; i++) begin
            if (pos == 4'(i)) begin
                for (int k = 0; k < osad_pkg::PairsPerB; k++) begin
                    id_out[4*i+k]              = id_in[4*i+k] | rbyte[2*k+1];
                    frame_out[8*i+2*k+1]       = frame_in[8*i+2*k+1] | rbyte[2*k+1];
                end
            end
        end
    end

endmodule

// ----- sv/osad_frame_finish.sv -----
module osad_frame_finish (
    input  logic [osad_pkg::FrameW-1:0] frame_in,
    input  osad_pkg::branch_t           branch,
    output logic [osad_pkg::FrameW-1:0] frame_out
);

    // take the branch the other way: direction bit set, all later pairs cleared
    always_comb begin
        frame_out = frame_in;
        if (branch.valid) begin
            for (int j = 0; j < osad_pkg::IdW; j++) begin
                if (6'(j) > branch.bit_idx) begin
                    frame_out[2*j]   = 1'b0;
                    frame_out[2*j+1] = 1'b0;
                end else if (6'(j) == branch.bit_idx) begin
                    frame_out[2*j+1] = 1'b1;
                end
            end
        end
    end

endmodule

// ----- sv/onewire_search_accel_decoder.sv -----
// m_tvalid rises in the cycle after the 16th accepted byte of a pass.
// Throughput: one byte per cycle; a single register stage (the search state
// plus the output register) carries each byte, and a held result stalls input.
// Reset (aresetn low, synchronous): request frame, id, branch record and byte
// position clear to zero, and no result is pending.
module onewire_search_accel_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [osad_pkg::ByteW-1:0]       s_tdata,  // [7:0] response_byte
    input  logic [0:0]                       s_tuser,  // [0] new_search
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [63:0] device_id, [127:64] next_frame_low, [191:128] next_frame_high,
    // [192] more_devices, [199:193] zero
    output logic [osad_pkg::OutDataW-1:0]    m_tdata
);

    logic [osad_pkg::FrameW-1:0] frame_reg, frame_next;
    logic [osad_pkg::IdW-1:0]    id_reg, id_next;
    osad_pkg::branch_t           branch_reg, branch_next;
    logic [osad_pkg::PosW-1:0]   pos_reg, pos_next;
    logic                        m_tvalid_reg;
    logic [osad_pkg::OutDataW-1:0] m_tdata_reg;

    logic                        s_xfer;
    logic                        last_byte;
    logic [osad_pkg::FrameW-1:0] frame_base, frame_dec, frame_fin;
    logic [osad_pkg::IdW-1:0]    id_base, id_dec;
    osad_pkg::branch_t           branch_base, branch_dec;
    logic [osad_pkg::PosW-1:0]   pos_base;

    // output register drains or is empty: take the next transaction
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // new_search clears state before the byte is applied
    always_comb begin
        if (s_tuser[0]) begin
            frame_base  = '0;
            id_base     = '0;
            branch_base = '0;
            pos_base    = '0;
        end else begin
            frame_base  = frame_reg;
            id_base     = id_reg;
            branch_base = branch_reg;
            pos_base    = pos_reg;
        end
    end

    osad_byte_decode u_decode (
        .pos        (pos_base),
        .rbyte      (s_tdata),
        .id_in      (id_base),
        .frame_in   (frame_base),
        .branch_in  (branch_base),
        .id_out     (id_dec),
        .frame_out  (frame_dec),
        .branch_out (branch_dec)
    );

    osad_frame_finish u_finish (
        .frame_in  (frame_dec),
        .branch    (branch_dec),
        .frame_out (frame_fin)
    );

    assign last_byte = (pos_base == 4'(osad_pkg::FrameBytes - 1));

    // next search state: pass end keeps only the frame
    always_comb begin
        if (last_byte) begin
            frame_next  = frame_fin;
            id_next     = '0;
            branch_next = '0;
            pos_next    = '0;
        end else begin
            frame_next  = frame_dec;
            id_next     = id_dec;
            branch_next = branch_dec;
            pos_next    = pos_base + 4'd1;
        end
    end

    // search state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg  <= '0;
            id_reg     <= '0;
            branch_reg <= '0;
            pos_reg    <= '0;
        end else if (s_xfer) begin
            frame_reg  <= frame_next;
            id_reg     <= id_next;
            branch_reg <= branch_next;
            pos_reg    <= pos_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_xfer && last_byte) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && last_byte) begin
            m_tdata_reg <= {7'b0, branch_dec.valid, frame_fin, id_dec};
        end
    end

endmodule

// ----- tb/sv/onewire_search_accel_decoder_tb.sv -----
`timescale 1ns / 100ps

module onewire_search_accel_decoder_tb;

    localparam int QuietLimit = 2000;

    // one search-pass result as it appears on m_tdata
    typedef struct packed {
        logic [osad_pkg::IdW-1:0] device_id;
        logic [63:0]              frame_low;
        logic [63:0]              frame_high;
        logic                     more_devices;
    } search_result_t;

    // how the random passes build their discrepancy and id bits
    typedef enum int {
        UNIFORM_PAIRS,
        SPARSE_BRANCHES,
        NO_BRANCH,
        ONE_BRANCH
    } pass_style_e;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [osad_pkg::ByteW-1:0]    s_tdata  = '0;   // [7:0] response_byte
    logic [0:0]                    s_tuser  = '0;   // [0] new_search
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // [63:0] device_id, [127:64] next_frame_low, [191:128] next_frame_high,
    // [192] more_devices, [199:193] zero
    logic [osad_pkg::OutDataW-1:0] m_tdata;

    // search state mirrored from the accepted transactions
    logic [osad_pkg::ByteW-1:0] req_frame [osad_pkg::FrameBytes] = '{default: '0};
    logic [osad_pkg::IdW-1:0]   id_acc      = '0;
    osad_pkg::branch_t          last_branch = '0;
    logic [osad_pkg::PosW-1:0]  byte_pos    = '0;

    search_result_t   pending_results[$];
    int               fail_count = 0;
    bit               idle_on    = 1'b0;
    int               stall_left = 0;
    int               quiet_cycles = 0;

    onewire_search_accel_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_pass_state();
        id_acc      = '0;
        last_branch = '0;
        byte_pos    = '0;
    endfunction

    // Fold one response byte into the search state; after the 16th byte of a
    // pass, build the next request frame and queue the expected result.
    function automatic void decode_response_byte(input logic [7:0] rb, input logic restart);
        search_result_t res;
        logic [5:0]     bit_n;
        logic [3:0]     br_byte;
        logic [1:0]     br_pair;
        if (restart) begin
            foreach (req_frame[i]) req_frame[i] = '0;
            clear_pass_state();
        end
        for (int k = 0; k < osad_pkg::PairsPerB; k++) begin
            bit_n = {byte_pos, 2'(k)};
            // discrepancy resolved toward 0 marks a branch
            if (rb[2*k] && !rb[2*k+1]) begin
                last_branch.valid   = 1'b1;
                last_branch.bit_idx = bit_n;
            end
            id_acc[bit_n]               |= rb[2*k+1];
            req_frame[byte_pos][2*k+1]  |= rb[2*k+1];
        end
        if (byte_pos != 4'(osad_pkg::FrameBytes - 1)) begin
            byte_pos++;
            return;
        end
        // take the branch toward 1 next time, drop every later pair
        if (last_branch.valid) begin
            br_byte = last_branch.bit_idx[5:2];
            br_pair = last_branch.bit_idx[1:0];
            req_frame[br_byte][2*br_pair+1] = 1'b1;
            req_frame[br_byte] &= 8'hFF >> (6 - 2*br_pair);
            for (int i = br_byte + 1; i < osad_pkg::FrameBytes; i++) req_frame[i] = '0;
        end
        res.device_id = id_acc;
        for (int i = 0; i < 8; i++) begin
            res.frame_low[8*i +: 8]  = req_frame[i];
            res.frame_high[8*i +: 8] = req_frame[i+8];
        end
        res.more_devices = last_branch.valid;
        pending_results.push_back(res);
        clear_pass_state();
    endfunction

    function automatic void check_field(input string name, input logic [63:0] expd,
                                        input logic [63:0] act);
        if (act !== expd) begin
            $error("%s: expected %h, got %h", name, expd, act);
            fail_count++;
        end
    endfunction

    // input monitor: predict on every accepted response byte
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            decode_response_byte(s_tdata, s_tuser[0]);
    end

    // result checker
    always @(posedge aclk) begin
        search_result_t expd;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no pass completed: %h", m_tdata);
                fail_count++;
            end else begin
                expd = pending_results.pop_front();
                check_field("device_id", expd.device_id, m_tdata[63:0]);
                check_field("next_frame_low", expd.frame_low, m_tdata[127:64]);
                check_field("next_frame_high", expd.frame_high, m_tdata[191:128]);
                check_field("more_devices", 64'(expd.more_devices), 64'(m_tdata[192]));
                check_field("pad", 64'd0, 64'(m_tdata[199:193]));
            end
        end
    end

    // receiver back-pressure in random bursts while idle_on is set
    always @(posedge aclk) begin
        if (!idle_on) begin
            stall_left <= 0;
            m_tready   <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog: too long without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("onewire_search_accel_decoder verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // drive one response byte and wait until it is taken
    task automatic send_byte(input logic [7:0] rb, input logic restart);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= rb;
        s_tuser[0] <= restart;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold the sender until every pass result has come out
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        // let the monitor see the last accepted byte first
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // branch only at bit 0; later bytes carry no branch
    task automatic test_branch_at_bit0();
        logic [7:0] fill [4] = '{8'hFF, 8'h00, 8'hAA, 8'hFE};
        send_byte(8'h01, 1'b1);
        for (int b = 1; b < osad_pkg::FrameBytes; b++) send_byte(fill[b % 4], 1'b0);
        wait_for_results();
    endtask

    // abandon a pass with branches, then a clean pass without any branch
    task automatic test_restart_mid_pass();
        send_byte(8'h55, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b1);
        for (int b = 1; b < osad_pkg::FrameBytes - 1; b++) send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_for_results();
    endtask

    // random passes, mostly whole passes with occasional restarts inside
    task automatic test_random_searches(input int passes);
        pass_style_e style;
        int          branch_at;
        logic [7:0]  rb;
        logic        restart;
        logic        disc;
        logic        idb;
        for (int p = 0; p < passes; p++) begin
            style     = pass_style_e'($urandom_range(0, 3));
            branch_at = $urandom_range(0, 63);
            for (int b = 0; b < osad_pkg::FrameBytes; b++) begin
                for (int k = 0; k < osad_pkg::PairsPerB; k++) begin
                    idb = 1'($urandom_range(0, 1));
                    case (style)
                        UNIFORM_PAIRS:   disc = 1'($urandom_range(0, 1));
                        SPARSE_BRANCHES: disc = ($urandom_range(0, 63) == 0);
                        NO_BRANCH:       disc = idb & 1'($urandom_range(0, 1));
                        default: begin
                            if (4*b + k == branch_at) begin
                                disc = 1'b1;
                                idb  = 1'b0;
                            end else begin
                                disc = idb & 1'($urandom_range(0, 1));
                            end
                        end
                    endcase
                    rb[2*k]   = disc;
                    rb[2*k+1] = idb;
                end
                if (b == 0) restart = ($urandom_range(0, 2) == 0);
                else        restart = ($urandom_range(0, 59) == 0);
                send_byte(rb, restart);
            end
            if ($urandom_range(0, 19) == 0) wait_for_results();
        end
        wait_for_results();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        idle_on <= 1'b1;
        test_branch_at_bit0();
        test_restart_mid_pass();
        test_random_searches(85);
        // closing stretch at full rate on both sides
        idle_on <= 1'b0;
        test_random_searches(15);
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("onewire_search_accel_decoder verification clean");
        end else begin
            $display("onewire_search_accel_decoder verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/osad_pkg.sv
sv/osad_byte_decode.sv
sv/osad_frame_finish.sv
sv/onewire_search_accel_decoder.sv
tb/sv/onewire_search_accel_decoder_tb.sv
